/* rtl/core/drum_voice_sine_noise_synth_macros.svh */
// ----------------------------------------------------------------------------
// Drum voice assertion macros
// Implication checks on the rising clock, held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DRUM_VOICE_SINE_NOISE_SYNTH_MACROS_SVH
`define DRUM_VOICE_SINE_NOISE_SYNTH_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define DVS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drum voice check failed");
// Next-cycle implication.
`define DVS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drum voice check failed");
`else
`define DVS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define DVS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/dvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice package
// Shared widths, codes, fixed-point constants and controller/datapath types.
// ----------------------------------------------------------------------------
package dvs_pkg;

    localparam int NOISE_W  = 16;
    localparam int SAMPLE_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CORD_W   = 34;
    localparam int ATAN_LEN = 24;
    localparam int IDX_W    = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRUM_KIND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd2;

    localparam logic [1:0]  DRUM_KIND_RST  = 2'd1;
    localparam logic [15:0] AMPLITUDE_RST  = 16'd1536;
    localparam logic [31:0] PHASE_STEP_RST = 32'd42852282;

    // Kit codes
    localparam logic [1:0] KIT_NONE = 2'd0;
    localparam logic [1:0] KIT_KICK = 2'd1;
    localparam logic [1:0] KIT_TOM1 = 2'd2;
    localparam logic [1:0] KIT_TOM2 = 2'd3;

    // Note kinds
    localparam logic NOTE_START = 1'b0;
    localparam logic NOTE_TICK  = 1'b1;

    localparam logic signed [CORD_W-1:0] GAIN_START = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] QTURN      = 34'sd1073741824;
    localparam logic signed [CORD_W-1:0] HTURN      = 34'sd2147483648;
    localparam logic signed [47:0] RES_A1 = 48'sd2119870719;
    localparam logic signed [47:0] RES_A2 = 48'sd1063031249;
    localparam logic signed [24:0] RES_A  = 25'sd13434475;
    localparam logic signed [24:0] C005   = 25'sd3277;
    localparam logic signed [24:0] C02    = 25'sd13107;

    // Arctangent of 2^-i in 2^-32 turns
    function automatic logic signed [CORD_W-1:0] atan_turn(input logic [IDX_W-1:0] i);
        logic signed [CORD_W-1:0] r;
        begin
            unique case (i)
                5'd0:    r = 34'sd536870912;
                5'd1:    r = 34'sd316933406;
                5'd2:    r = 34'sd167458907;
                5'd3:    r = 34'sd85005780;
                5'd4:    r = 34'sd42667331;
                5'd5:    r = 34'sd21354465;
                5'd6:    r = 34'sd10679838;
                5'd7:    r = 34'sd5340245;
                5'd8:    r = 34'sd2670163;
                5'd9:    r = 34'sd1335087;
                5'd10:   r = 34'sd667544;
                5'd11:   r = 34'sd333772;
                5'd12:   r = 34'sd166886;
                5'd13:   r = 34'sd83443;
                5'd14:   r = 34'sd41722;
                5'd15:   r = 34'sd20861;
                5'd16:   r = 34'sd10430;
                5'd17:   r = 34'sd5215;
                5'd18:   r = 34'sd2608;
                5'd19:   r = 34'sd1304;
                5'd20:   r = 34'sd652;
                5'd21:   r = 34'sd326;
                5'd22:   r = 34'sd163;
                5'd23:   r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLR_PHASE,
        OP_ADV,
        OP_LOAD_TURN,
        OP_LOAD_TURN2,
        OP_LOAD_NOISE,
        OP_CSTEP,
        OP_MUL_AS,
        OP_ACC26,
        OP_ACC27,
        OP_MUL_C005P,
        OP_ACC42,
        OP_MUL_RA,
        OP_ACC_RA,
        OP_MUL_RA1,
        OP_ADD_ACC,
        OP_MUL_RA2,
        OP_SUB_ACC,
        OP_RES_UPD,
        OP_MUL_RC02,
        OP_MUL_RC005,
        OP_ACC16,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kit;
        logic       out_free;
    } dp_stat_t;

endpackage

/* rtl/core/dvs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice channels
// Note request, audio sample and register write channels.
// ----------------------------------------------------------------------------
interface dvs_note_if import dvs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [NOISE_W-1:0] noise_draw;
    modport source(output valid, kind, noise_draw, input ready);
    modport sink(input valid, kind, noise_draw, output ready);
endinterface

interface dvs_audio_if import dvs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source(output valid, sample, input ready);
    modport sink(input valid, sample, output ready);
endinterface

interface dvs_cfg_if import dvs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/dvs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice controller
// Sequences phase update, CORDIC passes, multiplies and sample emit.
// ----------------------------------------------------------------------------
module dvs_ctrl
    import dvs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     note_valid,
    input  logic     note_kind,
    output logic     note_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [22:0] {
        S_IDLE    = 23'h000001,
        S_LOAD_T  = 23'h000002,
        S_STEP_T  = 23'h000004,
        S_MUL_AS  = 23'h000008,
        S_ACC_AS  = 23'h000010,
        S_MUL_C5  = 23'h000020,
        S_ACC_C5  = 23'h000040,
        S_LOAD_T2 = 23'h000080,
        S_STEP_T2 = 23'h000100,
        S_MUL_AS2 = 23'h000200,
        S_ACC_AS2 = 23'h000400,
        S_LOAD_N  = 23'h000800,
        S_STEP_N  = 23'h001000,
        S_MUL_RA  = 23'h002000,
        S_ACC_RA  = 23'h004000,
        S_MUL_RA1 = 23'h008000,
        S_ADD_RA1 = 23'h010000,
        S_MUL_RA2 = 23'h020000,
        S_SUB_RA2 = 23'h040000,
        S_RES_UPD = 23'h080000,
        S_MUL_RC  = 23'h100000,
        S_ACC_RC  = 23'h200000,
        S_FIN     = 23'h400000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CORDIC_STEPS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             last_step;

    assign last_step  = (cnt_reg == LAST_STEP);
    assign note_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_IDLE;
        cmd.idx    = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (note_valid)
                begin
                    if (note_kind == NOTE_TICK)
                    begin
                        cmd.op     = OP_ADV;
                        state_next = S_LOAD_T;
                    end
                    else
                    begin
                        cmd.op = OP_CLR_PHASE;
                    end
                end
            end
            S_LOAD_T:
            begin
                cmd.op     = OP_LOAD_TURN;
                cnt_next   = '0;
                state_next = S_STEP_T;
            end
            S_STEP_T:
            begin
                cmd.op   = OP_CSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = (stat.kit == KIT_NONE) ? S_FIN : S_MUL_AS;
            end
            S_MUL_AS:
            begin
                cmd.op     = OP_MUL_AS;
                state_next = (stat.kit == KIT_TOM1) ? S_MUL_C5 : S_ACC_AS;
            end
            S_ACC_AS:
            begin
                cmd.op     = OP_ACC26;
                state_next = (stat.kit == KIT_TOM2) ? S_LOAD_T2 : S_FIN;
            end
            S_MUL_C5:
            begin
                cmd.op     = OP_MUL_C005P;
                state_next = S_ACC_C5;
            end
            S_ACC_C5:
            begin
                cmd.op     = OP_ACC42;
                state_next = S_LOAD_N;
            end
            S_LOAD_T2:
            begin
                cmd.op     = OP_LOAD_TURN2;
                cnt_next   = '0;
                state_next = S_STEP_T2;
            end
            S_STEP_T2:
            begin
                cmd.op   = OP_CSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = S_MUL_AS2;
            end
            S_MUL_AS2:
            begin
                cmd.op     = OP_MUL_AS;
                state_next = S_ACC_AS2;
            end
            S_ACC_AS2:
            begin
                cmd.op     = OP_ACC27;
                state_next = S_LOAD_N;
            end
            S_LOAD_N:
            begin
                cmd.op     = OP_LOAD_NOISE;
                cnt_next   = '0;
                state_next = S_STEP_N;
            end
            S_STEP_N:
            begin
                cmd.op   = OP_CSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = S_MUL_RA;
            end
            S_MUL_RA:
            begin
                cmd.op     = OP_MUL_RA;
                state_next = S_ACC_RA;
            end
            S_ACC_RA:
            begin
                cmd.op     = OP_ACC_RA;
                state_next = S_MUL_RA1;
            end
            S_MUL_RA1:
            begin
                cmd.op     = OP_MUL_RA1;
                state_next = S_ADD_RA1;
            end
            S_ADD_RA1:
            begin
                cmd.op     = OP_ADD_ACC;
                state_next = S_MUL_RA2;
            end
            S_MUL_RA2:
            begin
                cmd.op     = OP_MUL_RA2;
                state_next = S_SUB_RA2;
            end
            S_SUB_RA2:
            begin
                cmd.op     = OP_SUB_ACC;
                state_next = S_RES_UPD;
            end
            S_RES_UPD:
            begin
                cmd.op     = OP_RES_UPD;
                state_next = S_MUL_RC;
            end
            S_MUL_RC:
            begin
                cmd.op     = (stat.kit == KIT_TOM1) ? OP_MUL_RC02 : OP_MUL_RC005;
                state_next = S_ACC_RC;
            end
            S_ACC_RC:
            begin
                cmd.op     = OP_ACC16;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/core/dvs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice datapath
// Registers, phase accumulator, CORDIC rotator, shared multiplier, resonator.
// ----------------------------------------------------------------------------
module dvs_datapath
    import dvs_pkg::*;
#(
    parameter int PHASE_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic [NOISE_W-1:0]         note_draw,
    input  logic                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_sample
);

    localparam int UP_SH = (PHASE_BITS >= 32) ? (PHASE_BITS - 32) : 0;
    localparam int DN_SH = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;
    localparam int WIDE  = PHASE_BITS + 32;

    logic [1:0]                 drum_kind_reg;
    logic [15:0]                amplitude_reg;
    logic [31:0]                phase_step_reg;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic signed [SAMPLE_W-1:0] res_last_reg, res_prev_reg;
    logic                       out_valid_reg;

    logic [NOISE_W-1:0]         draw_reg;
    logic signed [CORD_W-1:0]   x_reg, y_reg, z_reg;
    logic                       flip_reg;
    logic signed [63:0]         p_reg, acc_reg;
    logic signed [31:0]         sum_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [WIDE-1:0]            step_wide, turn_wide;
    logic [PHASE_BITS-1:0]      step;
    logic [31:0]                turn, turn_sel;
    logic signed [CORD_W-1:0]   z_in, z_fold, x_sh, y_sh, atan_v, s_val, c_val;
    logic                       flip_in;
    logic signed [47:0]         mul_a;
    logic signed [24:0]         mul_b;
    logic signed [72:0]         mul_p;
    logic signed [63:0]         r16, r26, r27, r42, r30;
    logic signed [SAMPLE_W-1:0] res_sat, sum_sat;

    // Align the configured step to the phase width and the phase to 32-bit turns
    assign step_wide = (WIDE'(phase_step_reg) << UP_SH) >> DN_SH;
    assign step      = step_wide[PHASE_BITS-1:0];
    assign turn_wide = (WIDE'(phase_reg) << DN_SH) >> UP_SH;
    assign turn      = turn_wide[31:0];

    always_comb
    begin
        unique case (cmd.op)
            OP_LOAD_TURN2: turn_sel = {turn[30:0], 1'b0};
            OP_LOAD_NOISE: turn_sel = {draw_reg, draw_reg};
            default:       turn_sel = turn;
        endcase
        // Fold into the right half plane
        z_in    = {{(CORD_W-32){turn_sel[31]}}, turn_sel};
        flip_in = 1'b0;
        z_fold  = z_in;
        if (z_in > QTURN)
        begin
            z_fold  = z_in - HTURN;
            flip_in = 1'b1;
        end
        else if (z_in < -QTURN)
        begin
            z_fold  = z_in + HTURN;
            flip_in = 1'b1;
        end
    end

    assign x_sh   = x_reg >>> cmd.idx;
    assign y_sh   = y_reg >>> cmd.idx;
    assign atan_v = atan_turn(cmd.idx);
    assign s_val  = flip_reg ? -y_reg : y_reg;
    assign c_val  = flip_reg ? -x_reg : x_reg;

    // Shared multiplier operand select
    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_AS:
            begin
                mul_a = {{(48-CORD_W){s_val[CORD_W-1]}}, s_val};
                mul_b = {9'd0, amplitude_reg};
            end
            OP_MUL_C005P:
            begin
                mul_a = p_reg[47:0];
                mul_b = C005;
            end
            OP_MUL_RA:
            begin
                mul_a = {{(48-CORD_W){c_val[CORD_W-1]}}, c_val};
                mul_b = RES_A;
            end
            OP_MUL_RA1:
            begin
                mul_a = RES_A1;
                mul_b = {res_last_reg[SAMPLE_W-1], res_last_reg};
            end
            OP_MUL_RA2:
            begin
                mul_a = RES_A2;
                mul_b = {res_prev_reg[SAMPLE_W-1], res_prev_reg};
            end
            OP_MUL_RC02:
            begin
                mul_a = {{(48-SAMPLE_W){res_last_reg[SAMPLE_W-1]}}, res_last_reg};
                mul_b = C02;
            end
            OP_MUL_RC005:
            begin
                mul_a = {{(48-SAMPLE_W){res_last_reg[SAMPLE_W-1]}}, res_last_reg};
                mul_b = C005;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round half up at each term's binary point
    assign r16 = (p_reg + 64'sd32768) >>> 16;
    assign r26 = (p_reg + 64'sd33554432) >>> 26;
    assign r27 = (p_reg + 64'sd67108864) >>> 27;
    assign r42 = (p_reg + 64'sd2199023255552) >>> 42;
    assign r30 = (acc_reg + 64'sd536870912) >>> 30;

    always_comb
    begin
        if (r30 > 64'sd8388607)
            res_sat = 24'sh7FFFFF;
        else if (r30 < -64'sd8388608)
            res_sat = -24'sh800000;
        else
            res_sat = r30[SAMPLE_W-1:0];
        if (sum_reg > 32'sd8388607)
            sum_sat = 24'sh7FFFFF;
        else if (sum_reg < -32'sd8388608)
            sum_sat = -24'sh800000;
        else
            sum_sat = sum_reg[SAMPLE_W-1:0];
    end

    // Architectural state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drum_kind_reg  <= DRUM_KIND_RST;
            amplitude_reg  <= AMPLITUDE_RST;
            phase_step_reg <= PHASE_STEP_RST;
            phase_reg      <= '0;
            res_last_reg   <= '0;
            res_prev_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_DRUM_KIND)
                    drum_kind_reg <= cfg_data[1:0];
                if (cfg_index == CFG_AMPLITUDE)
                    amplitude_reg <= cfg_data[15:0];
                if (cfg_index == CFG_PHASE_STEP)
                    phase_step_reg <= cfg_data;
            end
            if (cmd.op == OP_CLR_PHASE)
                phase_reg <= '0;
            else if (cmd.op == OP_ADV)
                phase_reg <= phase_reg + step;
            if (cmd.op == OP_RES_UPD)
            begin
                res_prev_reg <= res_last_reg;
                res_last_reg <= res_sat;
            end
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ADV:
            begin
                draw_reg <= note_draw;
                sum_reg  <= '0;
            end
            OP_LOAD_TURN, OP_LOAD_TURN2, OP_LOAD_NOISE:
            begin
                x_reg    <= GAIN_START;
                y_reg    <= '0;
                z_reg    <= z_fold;
                flip_reg <= flip_in;
            end
            OP_CSTEP:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_v;
                end
            end
            OP_MUL_AS, OP_MUL_C005P, OP_MUL_RA, OP_MUL_RA1, OP_MUL_RA2,
            OP_MUL_RC02, OP_MUL_RC005:
            begin
                p_reg <= mul_p[63:0];
            end
            OP_ACC16: sum_reg <= sum_reg + r16[31:0];
            OP_ACC26: sum_reg <= sum_reg + r26[31:0];
            OP_ACC27: sum_reg <= sum_reg + r27[31:0];
            OP_ACC42: sum_reg <= sum_reg + r42[31:0];
            OP_ACC_RA: acc_reg <= p_reg >>> 18;
            OP_ADD_ACC: acc_reg <= acc_reg + p_reg;
            OP_SUB_ACC: acc_reg <= acc_reg - p_reg;
            OP_EMIT: sample_reg <= sum_sat;
            default:
            begin
            end
        endcase
    end

    assign stat.kit      = drum_kind_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_sample    = sample_reg;

endmodule

/* rtl/core/drum_voice_sine_noise_synth.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice synthesizer
// Sine oscillator with optional second harmonic and resonated noise.
// ----------------------------------------------------------------------------
//   channel  role    payload
//   note     sink    kind (start/tick), noise_draw
//   audio    source  sample, signed Q11.12, saturated
//   cfg      sink    index, data (drum_kind, amplitude, phase_step)
//
// A start request only clears the phase. A tick makes one CORDIC pass for
// kick, two for tom one (phase, noise) and three for tom two (phase, double
// phase, noise), paced by the single CORDIC rotator stepping once per cycle;
// silent kit makes only the phase pass.
// Reset clears the phase, the resonator and restores register defaults.
// A stalled audio sink holds the finished sample in the output register;
// the next note is still accepted and stalls only when its own sample is due.
// ----------------------------------------------------------------------------
`include "drum_voice_sine_noise_synth_macros.svh"

module drum_voice_sine_noise_synth
    import dvs_pkg::*;
#(
    parameter int PHASE_BITS   = 32,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    dvs_note_if.sink   note,
    dvs_audio_if.source audio,
    dvs_cfg_if.sink    cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register writes are always taken; send them only while idle, as the block does not enforce it.
    assign cfg.ready = 1'b1;

    // Controller: owns the note handshake and sequences every step.
    dvs_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .note_valid(note.valid),
        .note_kind (note.kind),
        .note_ready(note.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: phase, rotator, multiplier, resonator and output register.
    dvs_datapath #(
        .PHASE_BITS(PHASE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .note_draw (note.noise_draw),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (audio.ready),
        .out_valid (audio.valid),
        .out_sample(audio.sample)
    );

    // A start request never produces a sample.
    `DVS_ASSERT_NXT(a_start_silent, clk, rst_n, note.valid && note.ready && !note.kind, !$rose(audio.valid))
    // A sample appears only as the controller returns to idle.
    `DVS_ASSERT_IMP(a_emit_idle, clk, rst_n, $rose(audio.valid), note.ready)
    // A tick request holds off further requests while it is worked.
    `DVS_ASSERT_NXT(a_tick_busy, clk, rst_n, note.valid && note.ready && note.kind, !note.ready)

endmodule

/* tb/tb_drum_voice_sine_noise_synth.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice synthesizer testbench
// Drives start and tick requests through the note channel and register writes
// through the config channel. A fixed-point model of the oscillator, the
// noise resonator and the mixer predicts every audio sample, and each sample
// is checked against the oldest prediction as it leaves the block.
// ----------------------------------------------------------------------------
module tb_drum_voice_sine_noise_synth;
    import dvs_pkg::*;

    localparam int  ROTATIONS   = 16;
    localparam int  SETTLE      = 120;     // longer than the slowest tick
    localparam longint LIMIT    = 2000000;

    // Arctangent of 2^-i in 2^-32 turns, one entry per rotation
    localparam longint ATAN_TURNS [0:15] = '{
        536870912, 316933406, 167458907, 85005780, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic clk;
    logic rst_n;

    dvs_note_if  note_ch();
    dvs_audio_if audio_ch();
    dvs_cfg_if   cfg_ch();

    drum_voice_sine_noise_synth dut (
        .clk   (clk),
        .rst_n (rst_n),
        .note  (note_ch),
        .audio (audio_ch),
        .cfg   (cfg_ch)
    );

    // Voice model state and register copies
    logic [1:0]  voice_kit;
    logic [15:0] voice_amp;
    logic [31:0] voice_step;
    logic [31:0] voice_phase;
    longint      res_last;
    longint      res_before;

    logic signed [SAMPLE_W-1:0] pending_samples[$];

    int  errors = 0;
    int  samples_checked = 0;
    int  notes_sent;
    int  writes_done;
    longint cycles = 0;
    bit  calm;          // when set, neither side idles

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if something hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d samples pending", cycles,
                     pending_samples.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d (sample %0d)", what, got,
                 want, samples_checked);
        errors++;
    endtask

    // ---------------------------------------------------------------- model

    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    // Rotation CORDIC on a 32-bit turn; folds the left half plane first
    task automatic rotate(input logic [31:0] turn, output longint sn,
                          output longint cs);
        longint z;
        longint x;
        longint y;
        longint t;
        bit     flip;
        z = longint'(turn);
        x = 652032874;
        y = 0;
        flip = 0;
        if (turn[31])
            z = z - 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z = z - 64'sd2147483648;
            flip = 1;
        end
        else if (z < -64'sd1073741824) begin
            z = z + 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_TURNS[i];
            end
            else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_TURNS[i];
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endtask

    // Advance the two-pole resonator with the cosine of the noise draw
    task automatic resonate_noise(input logic [15:0] draw, output longint nv);
        longint sn;
        longint cs;
        longint acc;
        logic [31:0] ang;
        ang = {draw, draw};
        rotate(ang, sn, cs);
        acc = ((64'sd13434475 * cs) >>> 18) + 64'sd2119870719 * res_last
            - 64'sd1063031249 * res_before;
        nv = clamp24(round_down_shift(acc, 30));
        res_before = res_last;
        res_last = nv;
    endtask

    // Apply one accepted note to the model and queue the sample it makes
    task automatic predict_note(input logic kind, input logic [15:0] draw);
        longint s1;
        longint s2;
        longint c;
        longint res;
        longint amp;
        longint mix;
        if (kind == NOTE_START) begin
            voice_phase = '0;
            return;
        end
        voice_phase = voice_phase + voice_step;
        amp = longint'(voice_amp);
        mix = 0;
        rotate(voice_phase, s1, c);
        case (voice_kit)
            KIT_KICK:
                mix = round_down_shift(amp * s1, 26);
            KIT_TOM1: begin
                resonate_noise(draw, res);
                mix = round_down_shift(amp * s1 * 3277, 42)
                    + round_down_shift(res * 13107, 16);
            end
            KIT_TOM2: begin
                rotate(voice_phase << 1, s2, c);
                resonate_noise(draw, res);
                mix = round_down_shift(amp * s1, 26)
                    + round_down_shift(amp * s2, 27)
                    + round_down_shift(res * 3277, 16);
            end
            default:
                mix = 0;    // silent kit: phase moves, resonator holds
        endcase
        pending_samples.push_back(SAMPLE_W'(clamp24(mix)));
    endtask

    // ------------------------------------------------------------- drivers

    function automatic bit want_idle();
        return !calm && ($urandom_range(99) < 19);
    endfunction

    // Send one note request; valid stays high for a back-to-back follow-up
    task automatic send_note(input logic kind, input logic [15:0] draw);
        @(negedge clk);
        while (want_idle()) begin
            note_ch.valid = 1'b0;
            @(negedge clk);
        end
        note_ch.valid      = 1'b1;
        note_ch.kind       = kind;
        note_ch.noise_draw = draw;
        @(posedge clk);
        while (!note_ch.ready)
            @(posedge clk);
        predict_note(kind, draw);
        notes_sent++;
    endtask

    // Drop valid and let every pending sample drain, then let the core settle
    task automatic drain();
        @(negedge clk);
        note_ch.valid = 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register while the core is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        drain();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_DRUM_KIND:  voice_kit  = value[1:0];
            CFG_AMPLITUDE:  voice_amp  = value[15:0];
            CFG_PHASE_STEP: voice_step = value;
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_voice(input logic [1:0] kit, input logic [15:0] amp,
                             input logic [31:0] step);
        // upper data bits are junk on purpose: the kit field must mask them
        write_reg(CFG_DRUM_KIND, {30'($urandom_range(32'h3fff_ffff)), kit});
        write_reg(CFG_AMPLITUDE, {16'($urandom), amp});
        write_reg(CFG_PHASE_STEP, step);
    endtask

    // Sample sink: stall at random, otherwise take every sample
    initial begin
        audio_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            audio_ch.ready = !want_idle();
        end
    end

    // Compare every accepted sample with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && audio_ch.valid && audio_ch.ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected sample", audio_ch.sample, 0);
            end
            else begin
                if (audio_ch.sample !== pending_samples[0])
                    report_mismatch("sample", audio_ch.sample, pending_samples[0]);
                void'(pending_samples.pop_front());
            end
            samples_checked++;
        end
    end

    // --------------------------------------------------------------- tests

    // Reset register values: a start, then a few kick ticks
    task automatic test_reset_voice();
        send_note(NOTE_START, 16'h0000);
        repeat (4) send_note(NOTE_TICK, 16'($urandom));
        drain();
    endtask

    // Field extremes, every kit, start mid-note, silent kit
    task automatic test_directed();
        set_voice(KIT_TOM1, 16'hffff, 32'hffff_ffff);
        send_note(NOTE_TICK, 16'h0000);
        send_note(NOTE_TICK, 16'hffff);
        send_note(NOTE_TICK, 16'h8000);
        send_note(NOTE_START, 16'hffff);
        send_note(NOTE_TICK, 16'h7fff);
        set_voice(KIT_TOM2, 16'hffff, 32'h8000_0000);
        send_note(NOTE_TICK, 16'hffff);
        send_note(NOTE_TICK, 16'h0000);
        send_note(NOTE_TICK, 16'h4000);
        set_voice(KIT_NONE, 16'h0100, 32'h4000_0000);
        // silent kit still advances the phase but leaves the resonator alone
        send_note(NOTE_TICK, 16'h1234);
        send_note(NOTE_TICK, 16'hc000);
        set_voice(KIT_KICK, 16'h0000, 32'h0000_0000);
        send_note(NOTE_TICK, 16'haaaa);
        send_note(NOTE_START, 16'h5555);
        set_voice(KIT_KICK, 16'hffff, 32'h2000_0000);
        repeat (4) send_note(NOTE_TICK, 16'h0001);
        set_voice(KIT_TOM2, 16'h8000, 32'h0000_0001);
        send_note(NOTE_START, 16'h0000);
        send_note(NOTE_TICK, 16'h0000);
        drain();
    endtask

    // Random voices, mostly tick runs with an occasional note start
    task automatic test_random_notes(input int phases, input int per_phase);
        logic [1:0]  kit;
        logic [15:0] amp;
        logic [31:0] step;
        for (int p = 0; p < phases; p++) begin
            kit = ($urandom_range(19) == 0) ? KIT_NONE : 2'($urandom_range(1, 3));
            case ($urandom_range(3))
                0:       amp = ($urandom_range(1)) ? 16'hffff : 16'h0000;
                default: amp = 16'($urandom);
            endcase
            case ($urandom_range(4))
                0:       step = ($urandom_range(1)) ? 32'hffff_ffff : 32'h0000_0000;
                1:       step = 32'($urandom_range(32'h00ff_ffff));
                default: step = $urandom;
            endcase
            set_voice(kit, amp, step);
            // hold the handshakes steady for one whole phase
            calm = (p == phases / 2);
            send_note(NOTE_START, 16'($urandom));
            for (int n = 0; n < per_phase; n++)
                send_note(($urandom_range(19) == 0) ? NOTE_START : NOTE_TICK,
                          16'($urandom));
            calm = 1'b0;
        end
        drain();
    endtask

    initial begin
        notes_sent = 0;
        writes_done = 0;
        calm = 1'b0;
        note_ch.valid = 1'b0;
        note_ch.kind = NOTE_START;
        note_ch.noise_draw = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_DRUM_KIND;
        cfg_ch.data = '0;
        voice_kit   = DRUM_KIND_RST;
        voice_amp   = AMPLITUDE_RST;
        voice_step  = PHASE_STEP_RST;
        voice_phase = '0;
        res_last    = 0;
        res_before  = 0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_voice();
        test_directed();
        test_random_notes(10, 115);

        $display("covered %0d note requests and %0d register writes", notes_sent,
                 writes_done);
        $display("checked %0d samples across all kits, %0d errors", samples_checked,
                 errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* drum_voice_sine_noise_synth.f */
+incdir+rtl/core
rtl/core/dvs_pkg.sv
rtl/core/dvs_if.sv
rtl/core/dvs_ctrl.sv
rtl/core/dvs_datapath.sv
rtl/core/drum_voice_sine_noise_synth.sv
tb/tb_drum_voice_sine_noise_synth.sv
